FILE: src/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, codes and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 4;

    // Fixed field widths of the word interfaces.
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CELL_W      = 16;
    localparam int COL_OUT_W   = 7;
    localparam int ROW_OUT_W   = 5;
    localparam int CFG_INDEX_W = 1;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Cell words and character codes.
    localparam logic [CELL_W-1:0] BLANK_WORD  = 16'h0720;
    localparam logic [CELL_W-1:0] GLYPH_RESET = 16'h875F;
    localparam logic [CHAR_W-1:0] ATTR_RESET  = 8'h07;
    localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NL     = 8'h0A;

    // Function codes of an input word.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEXT_ATTRIBUTE = 1'b0,
        REG_CURSOR_GLYPH   = 1'b1
    } cfg_reg_t;

    // Classified command kinds.
    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_TAB       = 3'd2,
        OP_NEWLINE   = 3'd3,
        OP_PRINT     = 3'd4
    } cmd_op_t;

    // One classified command as it travels through the queue.
    typedef struct packed {
        cmd_op_t             op;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } cmd_t;

    // Sequencer states of the back end.
    typedef enum logic [2:0] {
        BK_CLEAR       = 3'd0,
        BK_IDLE        = 3'd1,
        BK_READ_WAIT   = 3'd2,
        BK_ADVANCE     = 3'd3,
        BK_TAB         = 3'd4,
        BK_SCROLL_COPY = 3'd5,
        BK_SCROLL_FILL = 3'd6,
        BK_SCROLL_END  = 3'd7
    } back_state_t;

endpackage
`default_nettype wire

FILE: src/tcw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts input words and classifies them into console commands.
// ----------------------------------------------------------------------------
module tcw_front (
    input  wire logic                        start,
    input  wire logic                        func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0] cell_index,
    input  wire logic                        q_full,
    input  wire logic                        clearing,
    output logic                             busy,
    output logic                             push,
    output tcw_pkg::cmd_t                    cmd
);
    import tcw_pkg::*;

    // No word is taken while the queue is full or the store is being cleared.
    assign busy = q_full | clearing;
    assign push = start & ~busy;

    // Sort the word into a command kind; a read wins over any character.
    always_comb
    begin
        cmd.char_code  = char_code;
        cmd.cell_index = cell_index;
        priority if (func == FUNC_READ)
        begin
            cmd.op = OP_READ;
        end
        else if (char_code == CHAR_BS)
        begin
            cmd.op = OP_BACKSPACE;
        end
        else if (char_code == CHAR_TAB)
        begin
            cmd.op = OP_TAB;
        end
        else if (char_code == CHAR_NL)
        begin
            cmd.op = OP_NEWLINE;
        end
        else
        begin
            cmd.op = OP_PRINT;
        end
    end

endmodule
`default_nettype wire

FILE: src/tcw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tcw_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output tcw_pkg::cmd_t      head_cmd
);
    import tcw_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: src/tcw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the cursor and the cell store, and carries out console commands.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire tcw_pkg::cmd_t                 head_cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    text_attribute,
    input  wire logic [tcw_pkg::CELL_W-1:0]    cursor_glyph,
    output logic                               pop,
    output logic                               clearing,
    output logic                               done,
    output logic [tcw_pkg::COL_OUT_W-1:0]      cursor_column,
    output logic [tcw_pkg::ROW_OUT_W-1:0]      cursor_row,
    output logic [tcw_pkg::CELL_W-1:0]         cell_word,
    output logic                               did_scroll
);
    import tcw_pkg::*;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int COPY_N    = (ROWS - 1) * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int TAB_W     = $clog2(TAB_WIDTH + 1);
    localparam logic [AW-1:0] LAST_BASE = AW'(COPY_N);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [AW-1:0]      here_reg;
    logic [AW-1:0]      here_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [TAB_W-1:0]   tab_reg;
    logic [TAB_W-1:0]   tab_next;
    logic               scrolled_reg;
    logic               scrolled_next;
    logic               glyph_after_reg;
    logic               glyph_after_next;

    // Cell store and its ports.
    logic [CELL_W-1:0]  mem [CELLS];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [CELL_W-1:0]  rd_data_reg;

    // Result word.
    logic               emit;
    logic [CELL_W-1:0]  emit_word;
    logic               done_reg;
    logic [COL_OUT_W-1:0] col_out_reg;
    logic [ROW_OUT_W-1:0] row_out_reg;
    logic [CELL_W-1:0]  word_out_reg;
    logic               scroll_out_reg;

    // Helper conditions.
    logic               at_last_col;
    logic               at_last_row;
    logic               at_origin;
    logic [31:0]        index_ext;
    logic               index_in_range;
    logic [31:0]        col_ext;
    logic [31:0]        row_ext;

    assign at_last_col    = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row    = (row_reg == ROW_W'(ROWS - 1));
    assign at_origin      = (col_reg == '0) && (row_reg == '0);
    assign index_ext      = 32'(head_cmd.cell_index);
    assign index_in_range = (index_ext < 32'(CELLS));
    assign col_ext        = 32'(col_next);
    assign row_ext        = 32'(row_next);

    assign clearing = (state_reg == BK_CLEAR);
    assign pop      = (state_reg == BK_IDLE) && head_valid;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head_cmd.op)
                        OP_READ:
                        begin
                            state_next = index_in_range ? BK_READ_WAIT : BK_IDLE;
                        end
                        OP_TAB, OP_PRINT:
                        begin
                            state_next = BK_ADVANCE;
                        end
                        OP_NEWLINE:
                        begin
                            state_next = at_last_row ? BK_SCROLL_COPY : BK_IDLE;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_READ_WAIT:
            begin
                state_next = BK_IDLE;
            end
            BK_ADVANCE:
            begin
                if (at_last_col && at_last_row)
                begin
                    state_next = BK_SCROLL_COPY;
                end
                else if (tab_reg != '0)
                begin
                    state_next = BK_TAB;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_TAB:
            begin
                state_next = BK_ADVANCE;
            end
            BK_SCROLL_COPY:
            begin
                if (cnt_reg == CNT_W'(COPY_N))
                begin
                    state_next = BK_SCROLL_FILL;
                end
            end
            BK_SCROLL_FILL:
            begin
                if (cnt_reg == CNT_W'(COLUMNS - 1))
                begin
                    state_next = BK_SCROLL_END;
                end
            end
            BK_SCROLL_END:
            begin
                state_next = (glyph_after_reg && tab_reg != '0) ? BK_TAB : BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Cursor, counters, store accesses and result strobe for each state.
    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        here_next        = here_reg;
        cnt_next         = cnt_reg;
        tab_next         = tab_reg;
        scrolled_next    = scrolled_reg;
        glyph_after_next = glyph_after_reg;
        mem_we           = 1'b0;
        mem_waddr        = here_reg;
        mem_wdata        = BLANK_WORD;
        mem_re           = 1'b0;
        mem_raddr        = index_ext[AW-1:0];
        emit             = 1'b0;
        emit_word        = '0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                // Sweep the store once after reset; cell 0 holds the cursor glyph.
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                mem_wdata = (cnt_reg == '0) ? GLYPH_RESET : BLANK_WORD;
                cnt_next  = (cnt_reg == CNT_W'(CELLS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    scrolled_next = 1'b0;
                    tab_next      = '0;
                    unique case (head_cmd.op)
                        OP_READ:
                        begin
                            // Out-of-range reads answer zero at once.
                            if (index_in_range)
                            begin
                                mem_re = 1'b1;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            // Blank the previous cell and step back, wrapping to the row above.
                            if (!at_origin)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = here_reg - 1'b1;
                                here_next = here_reg - 1'b1;
                                if (col_reg == '0)
                                begin
                                    col_next = COL_W'(COLUMNS - 1);
                                    row_next = row_reg - 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                            emit = 1'b1;
                        end
                        OP_TAB:
                        begin
                            mem_we   = 1'b1;
                            tab_next = TAB_W'(TAB_WIDTH - 1);
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (at_last_row)
                            begin
                                here_next        = LAST_BASE;
                                scrolled_next    = 1'b1;
                                glyph_after_next = 1'b0;
                                cnt_next         = '0;
                            end
                            else
                            begin
                                row_next  = row_reg + 1'b1;
                                here_next = here_reg - AW'(col_reg) + AW'(COLUMNS);
                                emit      = 1'b1;
                            end
                        end
                        OP_PRINT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {text_attribute, head_cmd.char_code};
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ_WAIT:
            begin
                emit      = 1'b1;
                emit_word = rd_data_reg;
            end
            BK_ADVANCE:
            begin
                // Step right; a wrap off the last row starts a scroll instead.
                if (at_last_col && at_last_row)
                begin
                    col_next         = '0;
                    here_next        = LAST_BASE;
                    scrolled_next    = 1'b1;
                    glyph_after_next = 1'b1;
                    cnt_next         = '0;
                end
                else
                begin
                    if (at_last_col)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    here_next = here_reg + 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = here_reg + 1'b1;
                    mem_wdata = cursor_glyph;
                    if (tab_reg != '0)
                    begin
                        tab_next = tab_reg - 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            BK_TAB:
            begin
                mem_we = 1'b1;
            end
            BK_SCROLL_COPY:
            begin
                // Read one row ahead and write back the word read in the cycle before.
                if (cnt_reg != CNT_W'(COPY_N))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(cnt_reg) + AW'(COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(cnt_reg) - 1'b1;
                    mem_wdata = rd_data_reg;
                end
                cnt_next = (cnt_reg == CNT_W'(COPY_N)) ? '0 : cnt_reg + 1'b1;
            end
            BK_SCROLL_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = LAST_BASE + AW'(cnt_reg);
                mem_wdata = {text_attribute, SPACE_CHAR};
                cnt_next  = (cnt_reg == CNT_W'(COLUMNS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            BK_SCROLL_END:
            begin
                // An advance draws its glyph now; a newline just reports.
                if (glyph_after_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = cursor_glyph;
                    if (tab_reg != '0)
                    begin
                        tab_next = tab_reg - 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_CLEAR;
            col_reg         <= '0;
            row_reg         <= '0;
            here_reg        <= '0;
            cnt_reg         <= '0;
            tab_reg         <= '0;
            scrolled_reg    <= 1'b0;
            glyph_after_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            here_reg        <= here_next;
            cnt_reg         <= cnt_next;
            tab_reg         <= tab_next;
            scrolled_reg    <= scrolled_next;
            glyph_after_reg <= glyph_after_next;
            done_reg        <= emit;
        end
    end

    // Result word registers, loaded when a command finishes.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            col_out_reg    <= col_ext[COL_OUT_W-1:0];
            row_out_reg    <= row_ext[ROW_OUT_W-1:0];
            word_out_reg   <= emit_word;
            scroll_out_reg <= scrolled_next;
        end
    end

    // Cell store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign done          = done_reg;
    assign cursor_column = col_out_reg;
    assign cursor_row    = row_out_reg;
    assign cell_word     = word_out_reg;
    assign did_scroll    = scroll_out_reg;

endmodule
`default_nettype wire

FILE: src/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console over a 16-bit cell store with a software cursor.
//
//   Channel   Handshake          Words
//   input     start / busy       func, char_code, cell_index
//   result    done (one cycle)   cursor_column, cursor_row, cell_word, did_scroll
//   config    cfg_write          cfg_index, cfg_data
//
// A word is taken when start is high and busy is low; a two-deep queue lets the
// front take words while the back handles one command at a time. A read waits on
// the registered read port of the store. A scroll copies every row up one and
// fills the bottom row with spaces, through the single write port of the cell
// store. The result is registered when the command ends and is shown for one
// cycle. After reset the store is cleared one cell a cycle with busy high;
// configuration writes are taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    output logic                                 done,
    output logic [tcw_pkg::COL_OUT_W-1:0]        cursor_column,
    output logic [tcw_pkg::ROW_OUT_W-1:0]        cursor_row,
    output logic [tcw_pkg::CELL_W-1:0]           cell_word,
    output logic                                 did_scroll,
    input  wire logic                            cfg_write,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::CELL_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    logic               push;
    cmd_t               push_cmd;
    logic               q_full;
    logic               head_valid;
    cmd_t               head_cmd;
    logic               pop;
    logic               clearing;
    logic [CHAR_W-1:0]  attr_reg;
    logic [CELL_W-1:0]  glyph_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= ATTR_RESET;
            glyph_reg <= GLYPH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_TEXT_ATTRIBUTE)
            begin
                attr_reg <= cfg_data[CHAR_W-1:0];
            end
            else if (cfg_index == REG_CURSOR_GLYPH)
            begin
                glyph_reg <= cfg_data;
            end
        end
    end

    // Front end: accept and classify.
    tcw_front u_front (
        .start      (start),
        .func       (func),
        .char_code  (char_code),
        .cell_index (cell_index),
        .q_full     (q_full),
        .clearing   (clearing),
        .busy       (busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Command queue.
    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: cursor, cell store and results.
    tcw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .text_attribute (attr_reg),
        .cursor_glyph   (glyph_reg),
        .pop            (pop),
        .clearing       (clearing),
        .done           (done),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .cell_word      (cell_word),
        .did_scroll     (did_scroll)
    );

endmodule
`default_nettype wire

FILE: sim/console_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console result checker
// Watches the word, result and register channels of the text console writer.
// It keeps its own copy of the screen, the cursor and both registers, works
// out the result of every word the block takes, and compares each result
// word field by field with the oldest one still expected.
// ----------------------------------------------------------------------------
module console_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    input  wire logic                            done,
    input  wire logic [tcw_pkg::COL_OUT_W-1:0]   cursor_column,
    input  wire logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
    input  wire logic [tcw_pkg::CELL_W-1:0]      cell_word,
    input  wire logic                            did_scroll,
    input  wire logic                            cfg_write,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::CELL_W-1:0]      cfg_data,
    input  wire logic                            end_of_run,
    output int                                   pending,
    output int                                   fail_count
);

    import tcw_pkg::*;

    localparam int COLUMNS   = COLUMNS_DEF;
    localparam int ROWS      = ROWS_DEF;
    localparam int TAB_WIDTH = TAB_WIDTH_DEF;
    localparam int CELLS     = COLUMNS * ROWS;

    // One result word as the block should return it.
    typedef struct packed {
        logic [COL_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0] row;
        logic [CELL_W-1:0]    word;
        logic                 scrolled;
    } console_status_t;

    // Screen model, cursor and register copies.
    logic [CELL_W-1:0] screen [CELLS];
    int                cur_col;
    int                cur_row;
    logic [CHAR_W-1:0] attr_reg;
    logic [CELL_W-1:0] glyph_reg;
    bit                scrolled_now;
    bit                end_checked;

    console_status_t   expected_status [$];

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic int cursor_cell();
        return cur_row * COLUMNS + cur_col;
    endfunction

    // Move every row up by one and fill the new bottom row with spaces.
    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = {attr_reg, SPACE_CHAR};
        cur_row      = ROWS - 1;
        scrolled_now = 1'b1;
    endfunction

    // Step the cursor on, wrapping and scrolling, then draw the glyph.
    function automatic void advance_cursor();
        cur_col++;
        if (cur_col >= COLUMNS)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS)
            scroll_screen();
        screen[cursor_cell()] = glyph_reg;
    endfunction

    function automatic cmd_op_t classify_word(input logic f, input logic [CHAR_W-1:0] ch);
        if (f == FUNC_READ)
            return OP_READ;
        case (ch)
            CHAR_BS:  return OP_BACKSPACE;
            CHAR_TAB: return OP_TAB;
            CHAR_NL:  return OP_NEWLINE;
            default:  return OP_PRINT;
        endcase
    endfunction

    // Apply one input word to the screen model and return its result.
    function automatic console_status_t apply_console_word(
        input logic               f,
        input logic [CHAR_W-1:0]  ch,
        input logic [INDEX_W-1:0] idx
    );
        console_status_t   status;
        logic [CELL_W-1:0] word;
        word         = '0;
        scrolled_now = 1'b0;
        case (classify_word(f, ch))
            OP_READ:
            begin
                if (int'(idx) < CELLS)
                    word = screen[idx];
            end
            OP_BACKSPACE:
            begin
                // At the origin there is nothing to rub out.
                if (cur_col != 0 || cur_row != 0)
                begin
                    screen[cursor_cell() - 1] = BLANK_WORD;
                    if (cur_col == 0)
                    begin
                        cur_row--;
                        cur_col = COLUMNS - 1;
                    end
                    else
                    begin
                        cur_col--;
                    end
                end
            end
            OP_TAB:
            begin
                // The blank goes wherever the cursor is now, even after a scroll.
                repeat (TAB_WIDTH)
                begin
                    screen[cursor_cell()] = BLANK_WORD;
                    advance_cursor();
                end
            end
            OP_NEWLINE:
            begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= ROWS)
                    scroll_screen();
            end
            default:
            begin
                screen[cursor_cell()] = {attr_reg, ch};
                advance_cursor();
            end
        endcase
        status.column   = COL_OUT_W'(cur_col);
        status.row      = ROW_OUT_W'(cur_row);
        status.word     = word;
        status.scrolled = scrolled_now;
        return status;
    endfunction

    // Register writes, result comparison and prediction of accepted words.
    always @(posedge clk or negedge rst_n)
    begin : watch
        console_status_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = BLANK_WORD;
            screen[0]   = GLYPH_RESET;
            cur_col     = 0;
            cur_row     = 0;
            attr_reg    = ATTR_RESET;
            glyph_reg   = GLYPH_RESET;
            end_checked = 1'b0;
            fail_count  = 0;
            expected_status.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TEXT_ATTRIBUTE: attr_reg  = cfg_data[CHAR_W-1:0];
                    REG_CURSOR_GLYPH:   glyph_reg = cfg_data;
                    default:            ;
                endcase
            end

            // A result word is always for an earlier word, so compare first.
            if (done)
            begin
                if (expected_status.size() == 0)
                begin
                    report_mismatch("result word with nothing expected");
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (cursor_column !== want.column)
                        report_mismatch($sformatf("cursor_column %0d, expected %0d",
                                                  cursor_column, want.column));
                    if (cursor_row !== want.row)
                        report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                                  cursor_row, want.row));
                    if (cell_word !== want.word)
                        report_mismatch($sformatf("cell_word %h, expected %h",
                                                  cell_word, want.word));
                    if (did_scroll !== want.scrolled)
                        report_mismatch($sformatf("did_scroll %b, expected %b",
                                                  did_scroll, want.scrolled));
                end
            end

            if (start && !busy)
                expected_status.push_back(apply_console_word(func, char_code, cell_index));

            if (end_of_run && !end_checked)
            begin
                end_checked = 1'b1;
                if (expected_status.size() != 0)
                    report_mismatch($sformatf("%0d result words never arrived",
                                              expected_status.size()));
            end

            pending <= expected_status.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives directed and random character and read words into the console with
// random gaps, rewrites the attribute and glyph registers between phases, and
// leaves the checking to the console checker beside the block.
// ----------------------------------------------------------------------------
module testbench;

    import tcw_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam longint TIMEOUT_NS    = 100_000_000;
    localparam int     PHASES        = 6;
    localparam int     PHASE_WORDS   = 120;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     COLUMNS       = COLUMNS_DEF;
    localparam int     ROWS          = ROWS_DEF;
    localparam int     CELLS         = COLUMNS * ROWS;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 func;
    logic [CHAR_W-1:0]    char_code;
    logic [INDEX_W-1:0]   cell_index;
    logic                 done;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [CELL_W-1:0]    cell_word;
    logic                 did_scroll;
    logic                 cfg_write;
    cfg_reg_t             cfg_index;
    logic [CELL_W-1:0]    cfg_data;
    logic                 end_of_run;
    int                   pending;
    int                   fail_count;
    int                   burst_left;

    text_console_writer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .done          (done),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cell_word     (cell_word),
        .did_scroll    (did_scroll),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    console_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .done          (done),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cell_word     (cell_word),
        .did_scroll    (did_scroll),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .end_of_run    (end_of_run),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Hard limit on the length of the run.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Gap before the next word: mostly random, with bursts of back-to-back words.
    function automatic int draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 8)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Offer one word, wait until it is taken, then idle for a while.
    task automatic send_word(
        input logic               f,
        input logic [CHAR_W-1:0]  ch,
        input logic [INDEX_W-1:0] idx
    );
        int gap;
        bit hold_off;
        start      <= 1'b1;
        func       <= f;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap      = draw_gap();
        hold_off = ($urandom_range(0, 99) < 3);
        if (gap != 0 || hold_off)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
            // Now and then let every outstanding result drain first.
            if (hold_off)
            begin
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait until every expected result word has come back.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write both registers on consecutive cycles; the attribute's upper byte is noise.
    task automatic set_registers(input logic [CHAR_W-1:0] attr, input logic [CELL_W-1:0] glyph);
        cfg_write <= 1'b1;
        cfg_index <= REG_TEXT_ATTRIBUTE;
        cfg_data  <= {8'($urandom_range(0, 255)), attr};
        @(posedge clk);
        cfg_index <= REG_CURSOR_GLYPH;
        cfg_data  <= glyph;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One phase of random traffic built from short runs of related words.
    task automatic run_random_phase(input int words);
        int                 sent;
        int                 kind;
        int                 len;
        logic [INDEX_W-1:0] idx;
        sent = 0;
        while (sent < words)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                // A short run of text, often ended by a newline.
                len = $urandom_range(1, 8);
                repeat (len)
                    send_word(FUNC_WRITE, 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, 2047)));
                sent += len;
                if ($urandom_range(0, 1) == 1)
                begin
                    send_word(FUNC_WRITE, CHAR_NL, 11'($urandom_range(0, 2047)));
                    sent++;
                end
            end
            else if (kind < 44)
            begin
                // A long line that wraps, closed by a tab near the row end.
                len = $urandom_range(60, 85);
                repeat (len)
                    send_word(FUNC_WRITE, 8'($urandom_range(32, 126)), '0);
                send_word(FUNC_WRITE, CHAR_TAB, '0);
                sent += len + 1;
            end
            else if (kind < 66)
            begin
                // Reads spread over the screen, the bottom row and beyond the end.
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: idx = 11'($urandom_range(0, CELLS - 1));
                        6, 7:             idx = 11'($urandom_range(CELLS - COLUMNS, CELLS - 1));
                        8:                idx = 11'($urandom_range(CELLS, 2047));
                        default:          idx = 11'($urandom_range(0, COLUMNS - 1));
                    endcase
                    send_word(FUNC_READ, 8'($urandom_range(0, 255)), idx);
                end
                sent += len;
            end
            else if (kind < 78)
            begin
                // Backspaces, often straight after a newline to cross a row.
                if ($urandom_range(0, 1) == 1)
                begin
                    send_word(FUNC_WRITE, CHAR_NL, '0);
                    sent++;
                end
                len = $urandom_range(1, 5);
                repeat (len)
                    send_word(FUNC_WRITE, CHAR_BS, 11'($urandom_range(0, 2047)));
                sent += len;
            end
            else if (kind < 88)
            begin
                len = $urandom_range(1, 3);
                repeat (len)
                    send_word(FUNC_WRITE, CHAR_TAB, 11'($urandom_range(0, 2047)));
                sent += len;
            end
            else
            begin
                // Fully random words.
                len = $urandom_range(1, 6);
                repeat (len)
                    send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, 2047)));
                sent += len;
            end
        end
    endtask

    // Reset, directed words, then random phases under changing registers.
    initial
    begin : stimulus
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = FUNC_WRITE;
        char_code  = '0;
        cell_index = '0;
        cfg_write  = 1'b0;
        cfg_index  = REG_TEXT_ATTRIBUTE;
        cfg_data   = '0;
        end_of_run = 1'b0;
        burst_left = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed words with the registers at their reset values.
        send_word(FUNC_READ,  8'h00,    11'd0);
        send_word(FUNC_WRITE, CHAR_BS,  11'd0);
        send_word(FUNC_WRITE, 8'h41,    11'd0);
        send_word(FUNC_WRITE, 8'h00,    11'h7FF);
        send_word(FUNC_WRITE, 8'hFF,    11'd0);
        send_word(FUNC_WRITE, CHAR_BS,  11'd0);
        send_word(FUNC_WRITE, CHAR_TAB, 11'd0);
        send_word(FUNC_WRITE, CHAR_NL,  11'd0);
        send_word(FUNC_WRITE, CHAR_BS,  11'd0);
        send_word(FUNC_READ,  8'hFF,    11'd79);
        send_word(FUNC_READ,  8'h00,    11'd1);
        send_word(FUNC_READ,  8'h00,    11'd2);
        send_word(FUNC_READ,  8'h00,    11'(CELLS - 1));
        send_word(FUNC_READ,  8'h00,    11'(CELLS));
        send_word(FUNC_READ,  8'h00,    11'h7FF);
        send_word(FUNC_WRITE, CHAR_NL,  11'd0);
        send_word(FUNC_WRITE, CHAR_NL,  11'd0);
        send_word(FUNC_WRITE, 8'h20,    11'd0);
        send_word(FUNC_READ,  8'h00,    11'd1024);
        send_word(FUNC_READ,  8'h00,    11'(2 * COLUMNS));
        send_word(FUNC_READ,  8'h00,    11'(2 * COLUMNS + 1));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:       set_registers(8'hFF, 16'h0000);
                1:       set_registers(8'h00, 16'hFFFF);
                default: set_registers(8'($urandom_range(0, 255)),
                                       16'($urandom_range(0, 65535)));
            endcase
            if (p == 0)
            begin
                // Walk down to the bottom row, then newline, wrap and tab there.
                repeat (ROWS + 1)
                    send_word(FUNC_WRITE, CHAR_NL, '0);
                repeat (COLUMNS - 3)
                    send_word(FUNC_WRITE, 8'($urandom_range(32, 126)), '0);
                send_word(FUNC_WRITE, CHAR_TAB, '0);
                repeat (COLUMNS)
                    send_word(FUNC_WRITE, 8'($urandom_range(32, 126)), '0);
                send_word(FUNC_READ, 8'h00, 11'(CELLS - COLUMNS));
            end
            run_random_phase(PHASE_WORDS);
        end

        wait_idle();
        end_of_run <= 1'b1;
        repeat (2)
            @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer.sv
sim/console_checker.sv
sim/testbench.sv
